>>> rtl/core/tpsf_pkg.sv
package tpsf_pkg;

   // Default sizes of the pattern tile memory and the longest span.
   localparam int TILE_MAX_W_DEF = 64;
   localparam int TILE_MAX_H_DEF = 64;
   localparam int MAX_SPAN_DEF   = 64;

   // Fixed field widths.
   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 12;
   localparam int WORD_W  = 32;
   localparam int COORD_W = 12;
   localparam int DIM_W   = 7;
   localparam int SPAN_W  = 7;
   localparam int BPP_W   = 3;
   localparam int STRIDE_W = 15;
   localparam int CSR_IDX_W = 3;
   localparam int PAL_W   = 24;
   localparam int PAL_AW  = 8;

   // The modulo dividend is origin plus position, one bit wider than a coordinate.
   localparam int DIVD_W    = COORD_W + 1;
   localparam int MOD_STEPS = DIVD_W;

   // Request functions.
   localparam logic [FUNC_W-1:0] FUNC_PAT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PAL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FILL = 2'd2;

   // Pixel modes.
   localparam logic [BPP_W-1:0] MODE_RGB332 = 3'd1;
   localparam logic [BPP_W-1:0] MODE_16     = 3'd2;
   localparam logic [BPP_W-1:0] MODE_24     = 3'd3;
   localparam logic [BPP_W-1:0] MODE_32     = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BPP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_W = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_H = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORG_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ORG_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BASE   = 3'd6;

   typedef struct packed {
      logic [BPP_W-1:0]    bpp;
      logic [DIM_W-1:0]    tile_width;
      logic [DIM_W-1:0]    tile_height;
      logic [COORD_W-1:0]  origin_x;
      logic [COORD_W-1:0]  origin_y;
      logic [STRIDE_W-1:0] dest_stride;
      logic [WORD_W-1:0]   dest_base;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic load_pat;
      logic load_pal;
      logic mod_step;
      logic setup;
      logic issue;
      logic issue_last;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } sts_type;

endpackage

>>> rtl/core/tpsf_csr.sv
module tpsf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tpsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpsf_pkg::WORD_W-1:0]   csr_wdata,
   output tpsf_pkg::cfg_type             cfg
);
   import tpsf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_BPP:    cfg_in.bpp         = csr_wdata[BPP_W-1:0];
            REG_TILE_W: cfg_in.tile_width  = csr_wdata[DIM_W-1:0];
            REG_TILE_H: cfg_in.tile_height = csr_wdata[DIM_W-1:0];
            REG_ORG_X:  cfg_in.origin_x    = csr_wdata[COORD_W-1:0];
            REG_ORG_Y:  cfg_in.origin_y    = csr_wdata[COORD_W-1:0];
            REG_STRIDE: cfg_in.dest_stride = csr_wdata[STRIDE_W-1:0];
            REG_BASE:   cfg_in.dest_base   = csr_wdata;
            default:    cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bpp         <= MODE_32;
         cfg_ff.tile_width  <= DIM_W'(64);
         cfg_ff.tile_height <= DIM_W'(64);
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.dest_stride <= STRIDE_W'(256);
         cfg_ff.dest_base   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/tpsf_ctrl.sv
module tpsf_ctrl #(
   parameter int MAX_SPAN = tpsf_pkg::MAX_SPAN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tpsf_pkg::FUNC_W-1:0]  req_func,
   input  logic [tpsf_pkg::SPAN_W-1:0]  req_span_length,
   input  tpsf_pkg::cfg_type            cfg,
   input  tpsf_pkg::sts_type            sts,
   output tpsf_pkg::cmd_type            cmd
);
   import tpsf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MOD   = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [SPAN_W-1:0] cnt_ff, cnt_in;
   logic [SPAN_W-1:0] len_ff, len_in;
   logic              accept;
   logic              mode_ok;
   logic [SPAN_W-1:0] len_sat;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign mode_ok = (cfg.bpp >= MODE_RGB332) && (cfg.bpp <= MODE_32);
   assign len_sat = (int'(req_span_length) > MAX_SPAN) ? SPAN_W'(MAX_SPAN)
                                                       : req_span_length;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture  = 1'b1;
               cmd.load_pat = (req_func == FUNC_PAT);
               cmd.load_pal = (req_func == FUNC_PAL);
               len_in       = len_sat;
               cnt_in       = SPAN_W'(MOD_STEPS - 1);
               if (req_func == FUNC_FILL && mode_ok && len_sat != '0) begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = len_ff;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            cmd.issue      = 1'b1;
            cmd.issue_last = (cnt_ff == SPAN_W'(1));
            cnt_in         = cnt_ff - 1'b1;
            if (cnt_ff == SPAN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
      end
   end

endmodule

>>> rtl/core/tpsf_dp.sv
module tpsf_dp #(
   parameter int TILE_MAX_W = tpsf_pkg::TILE_MAX_W_DEF,
   parameter int TILE_MAX_H = tpsf_pkg::TILE_MAX_H_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpsf_pkg::cmd_type             cmd,
   output tpsf_pkg::sts_type             sts,
   input  tpsf_pkg::cfg_type             cfg,
   input  logic [tpsf_pkg::IDX_W-1:0]    req_load_index,
   input  logic [tpsf_pkg::WORD_W-1:0]   req_load_value,
   input  logic [tpsf_pkg::COORD_W-1:0]  req_row,
   input  logic [tpsf_pkg::COORD_W-1:0]  req_first_x,
   output logic                          rsp_valid,
   output logic [tpsf_pkg::WORD_W-1:0]   rsp_dest_addr,
   output logic [tpsf_pkg::WORD_W-1:0]   rsp_pixel,
   output logic                          rsp_last
);
   import tpsf_pkg::*;

   localparam int PAT_DEPTH = TILE_MAX_W * TILE_MAX_H;
   localparam int PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
   localparam int PROD_W    = COORD_W + STRIDE_W;
   localparam int XOFF_W    = COORD_W + BPP_W;
   localparam int SUM_W     = PROD_W + 1;

   function automatic logic [7:0] pack_332(input logic [PAL_W-1:0] rgb);
      pack_332 = {rgb[23:21], rgb[15:13], rgb[7:6]};
   endfunction

   // Memories.
   logic [WORD_W-1:0] pat_mem [PAT_DEPTH];
   logic [PAL_W-1:0]  pal_mem [256];

   // Captured request and setup values.
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] x0_ff;
   logic [DIVD_W-1:0]  divx_ff, divx_in;
   logic [DIVD_W-1:0]  divy_ff, divy_in;
   logic [DIM_W-1:0]   remx_ff, remx_in;
   logic [DIM_W-1:0]   remy_ff, remy_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [XOFF_W-1:0]  xoff_ff;
   logic [SUM_W-1:0]   sum_ff;

   // Walk state.
   logic [PAT_AW-1:0]  row_base_ff;
   logic [DIM_W-1:0]   sx_ff, sx_in;
   logic [WORD_W-1:0]  addr_ff;
   logic [PAT_AW-1:0]  pat_ra;

   // Read pipeline.
   logic               s1_valid_ff, s1_last_ff;
   logic [WORD_W-1:0]  s1_addr_ff;
   logic [WORD_W-1:0]  pat_q_ff;
   logic               s2_valid_ff, s2_last_ff;
   logic [WORD_W-1:0]  s2_addr_ff;
   logic [WORD_W-1:0]  s2_pat_ff;
   logic [PAL_W-1:0]   pal_q_ff;
   logic [WORD_W-1:0]  pixel_in;

   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_addr_ff;
   logic [WORD_W-1:0]  rsp_pixel_ff;
   logic               rsp_last_ff;

   logic [DIM_W-1:0]   tw, th;
   logic [DIM_W:0]     remx_t, remy_t;
   logic [DIM_W:0]     sx_next;
   logic               pat_we, pal_we;

   // Clamp the tile size to 1 .. maximum.
   always_comb begin
      if (cfg.tile_width == '0) begin
         tw = DIM_W'(1);
      end else if (int'(cfg.tile_width) > TILE_MAX_W) begin
         tw = DIM_W'(TILE_MAX_W);
      end else begin
         tw = cfg.tile_width;
      end
      if (cfg.tile_height == '0) begin
         th = DIM_W'(1);
      end else if (int'(cfg.tile_height) > TILE_MAX_H) begin
         th = DIM_W'(TILE_MAX_H);
      end else begin
         th = cfg.tile_height;
      end
   end

   // One restoring remainder step per cycle for both axes, most significant bit first.
   always_comb begin
      remx_t  = {remx_ff, divx_ff[DIVD_W-1]};
      remy_t  = {remy_ff, divy_ff[DIVD_W-1]};
      remx_in = (remx_t >= {1'b0, tw}) ? DIM_W'(remx_t - {1'b0, tw}) : DIM_W'(remx_t);
      remy_in = (remy_t >= {1'b0, th}) ? DIM_W'(remy_t - {1'b0, th}) : DIM_W'(remy_t);
      divx_in = {divx_ff[DIVD_W-2:0], 1'b0};
      divy_in = {divy_ff[DIVD_W-2:0], 1'b0};
   end

   always_comb begin
      sx_next = {1'b0, sx_ff} + 1'b1;
      sx_in   = (sx_next >= {1'b0, tw}) ? '0 : DIM_W'(sx_next);
      pat_ra  = row_base_ff + PAT_AW'(sx_ff);
   end

   assign pat_we = cmd.load_pat && (int'(req_load_index) < PAT_DEPTH);
   assign pal_we = cmd.load_pal && (req_load_index[IDX_W-1:PAL_AW] == '0);

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[PAT_AW'(req_load_index)] <= req_load_value;
      end
      pat_q_ff <= pat_mem[pat_ra];
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[req_load_index[PAL_AW-1:0]] <= req_load_value[PAL_W-1:0];
      end
      pal_q_ff <= pal_mem[pat_q_ff[PAL_AW-1:0]];
   end

   // Capture, remainder steps, setup arithmetic (row offset, column offset, start address) and walk stepping.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff  <= req_row;
         x0_ff   <= req_first_x;
         divx_ff <= {1'b0, cfg.origin_x} + {1'b0, req_first_x};
         divy_ff <= {1'b0, cfg.origin_y} + {1'b0, req_row};
         remx_ff <= '0;
         remy_ff <= '0;
      end else if (cmd.mod_step) begin
         divx_ff <= divx_in;
         divy_ff <= divy_in;
         remx_ff <= remx_in;
         remy_ff <= remy_in;
      end
      prod_ff <= row_ff * cfg.dest_stride;
      xoff_ff <= x0_ff * cfg.bpp;
      sum_ff  <= {1'b0, prod_ff} + SUM_W'(xoff_ff);
      if (cmd.setup) begin
         row_base_ff <= PAT_AW'(remy_ff) * PAT_AW'(TILE_MAX_W);
         sx_ff       <= remx_ff;
         addr_ff     <= cfg.dest_base + WORD_W'(sum_ff);
      end else if (cmd.issue) begin
         sx_ff   <= sx_in;
         addr_ff <= addr_ff + WORD_W'(cfg.bpp);
      end
   end

   always_comb begin
      unique case (cfg.bpp)
         MODE_RGB332: pixel_in = WORD_W'(pack_332(pal_q_ff));
         MODE_16:     pixel_in = {16'b0, s2_pat_ff[15:0]};
         MODE_24:     pixel_in = {8'b0, s2_pat_ff[23:0]};
         default:     pixel_in = s2_pat_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= addr_ff;
      s1_last_ff   <= cmd.issue_last;
      s2_addr_ff   <= s1_addr_ff;
      s2_last_ff   <= s1_last_ff;
      s2_pat_ff    <= pat_q_ff;
      rsp_addr_ff  <= s2_addr_ff;
      rsp_last_ff  <= s2_last_ff;
      rsp_pixel_ff <= pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign sts.pipe_busy = s1_valid_ff || s2_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dest_addr = rsp_addr_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> rtl/core/tiled_pattern_span_fill_core.sv
// Span fill from a repeating pattern tile held in internal memory.
// Requests enter on start while busy is low. A request loads one pattern pixel,
// loads one palette entry, or fills one span of up to MAX_SPAN pixels.
// Loads give no result. A fill computes the start tile
// column and row with a bit-serial remainder unit, passes a setup state,
// then issues one pixel per cycle; each pixel passes the pattern memory
// read, the palette read and the output register.
// A fill holds busy from acceptance until its last result is presented,
// and its results appear on rsp_valid back to back, the last one marked.
// Every result is shown for exactly one cycle; the receiver cannot stall.
// Registers are written through the csr channel (always ready) and must only
// change while busy is low and no result is outstanding.
// Reset returns the registers to their defaults and empties the pipeline;
// the pattern and palette memories are not cleared and must be loaded before
// they are read.
module tiled_pattern_span_fill_core #(
   parameter int TILE_MAX_W = tpsf_pkg::TILE_MAX_W_DEF,
   parameter int TILE_MAX_H = tpsf_pkg::TILE_MAX_H_DEF,
   parameter int MAX_SPAN   = tpsf_pkg::MAX_SPAN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tpsf_pkg::FUNC_W-1:0]    req_func,
   input  logic [tpsf_pkg::IDX_W-1:0]     req_load_index,
   input  logic [tpsf_pkg::WORD_W-1:0]    req_load_value,
   input  logic [tpsf_pkg::COORD_W-1:0]   req_row,
   input  logic [tpsf_pkg::COORD_W-1:0]   req_first_x,
   input  logic [tpsf_pkg::SPAN_W-1:0]    req_span_length,
   output logic                           rsp_valid,
   output logic [tpsf_pkg::WORD_W-1:0]    rsp_dest_addr,
   output logic [tpsf_pkg::WORD_W-1:0]    rsp_pixel,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tpsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpsf_pkg::WORD_W-1:0]    csr_wdata
);
   import tpsf_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   tpsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpsf_ctrl #(
      .MAX_SPAN (MAX_SPAN)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_span_length (req_span_length),
      .cfg             (cfg),
      .sts             (sts),
      .cmd             (cmd)
   );

   tpsf_dp #(
      .TILE_MAX_W (TILE_MAX_W),
      .TILE_MAX_H (TILE_MAX_H)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .cfg            (cfg),
      .req_load_index (req_load_index),
      .req_load_value (req_load_value),
      .req_row        (req_row),
      .req_first_x    (req_first_x),
      .rsp_valid      (rsp_valid),
      .rsp_dest_addr  (rsp_dest_addr),
      .rsp_pixel      (rsp_pixel),
      .rsp_last       (rsp_last)
   );

endmodule
